@@ hdl/fba_pkg.sv @@
// Shared types, constants and helpers for the frame bitmap allocator.
// Used by the top level; depends on nothing else.
package fba_pkg;

    localparam int PF_W      = 12;
    localparam int CNT_W     = 13;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    localparam logic [CNT_W-1:0] COUNT_RESET = 13'd4096;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_HELD      = 2'd1;
    localparam logic [1:0] ST_NOT_HELD  = 2'd2;
    localparam logic [1:0] ST_NO_MEMORY = 2'd3;

    typedef struct packed {
        logic            req_type;
        logic [PF_W-1:0] page_frame;
        logic            want_present;
        logic            want_writeable;
        logic            want_user;
    } req_t;

    typedef struct packed {
        logic [PF_W-1:0] result_frame;
        logic            present_bit;
        logic            writeable_bit;
        logic            user_bit;
        logic [1:0]      status;
    } resp_t;

    // Index of the lowest clear bit; only meaningful when some bit is clear.
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ hdl/fba_bitmap_ram.sv @@
// Bitmap word memory with registered read and per-word valid bits.
// A word never written since reset reads as all zeros. Depends on nothing else.
module fba_bitmap_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7,
    parameter int WIDTH  = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

@@ hdl/frame_bitmap_allocator.sv @@
// Frame bitmap allocator: first-fit page frame allocation over a bitmap in memory.
// Requests that touch no bitmap word (refusals, frees of frame 0 or past the bitmap,
// allocations under a count below one word) are answered straight from IDLE; a free does
// one read-modify-write; an allocation scans words upward from zero to the first with a clear bit.
// Handshake: one request at a time; the next transfer is taken in the cycle of the result
// strobe. The receiver cannot stall: results are one-cycle strobes. Reset clears the bitmap at once.
module frame_bitmap_allocator #(
    parameter int MAX_FRAMES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fba_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic                          start,
    input  fba_pkg::req_t                 req,
    output logic                          busy,
    output logic                          done,
    output fba_pkg::resp_t                result
);

    import fba_pkg::*;

    // Bitmap geometry. The word width is fixed; the number of words follows the
    // frame capacity, rounded up so a partial last word still has storage.
    localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LIM_W     = ($clog2(MAX_FRAMES + 1) > CNT_W) ?
                               $clog2(MAX_FRAMES + 1) : CNT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FREE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [ADDR_W-1:0]      idx_reg, idx_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [2:0]             flags_reg, flags_next;
    logic                   done_reg, done_next;
    resp_t                  res_reg, res_next;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;

    logic [LIM_W-1:0]       limit;
    logic [LIM_W-1:0]       words;
    logic [ADDR_W:0]        idx_plus;
    logic [BIT_W-1:0]       zero_bit;
    logic [ADDR_W+BIT_W-1:0] found_frame;

    // The bitmap itself: one word per 32 frames, a set bit marks a used frame.
    fba_bitmap_ram #(
        .DEPTH  (NUM_WORDS),
        .ADDR_W (ADDR_W),
        .WIDTH  (WORD_BITS)
    ) u_bitmap (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Only whole words below the clamped frame count are searched.
    always_comb
    begin
        if (LIM_W'(count_reg) > LIM_W'(MAX_FRAMES))
        begin
            limit = LIM_W'(MAX_FRAMES);
        end
        else
        begin
            limit = LIM_W'(count_reg);
        end
    end

    assign words       = limit >> BIT_W;
    assign idx_plus    = {1'b0, idx_reg} + (ADDR_W+1)'(1);
    assign zero_bit    = first_zero(ram_rdata);
    assign found_frame = {idx_reg, zero_bit};

    // Sequencer. In IDLE a request is decoded; requests that touch no state are
    // answered straight away. An allocation then reads words from zero upward,
    // one per cycle with the next read issued while the current word is checked,
    // and writes back the first word with a clear bit. A free does one
    // read-modify-write. Only one request is in flight, so a write back is always
    // finished before the next request issues its first read.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        bit_next   = bit_reg;
        flags_next = flags_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = '0;
        ram_raddr  = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next = '0;
                    if (req.req_type == REQ_ALLOC)
                    begin
                        if (req.page_frame != '0)
                        begin
                            done_next             = 1'b1;
                            res_next.result_frame = req.page_frame;
                            res_next.status       = ST_HELD;
                        end
                        else if (words == '0)
                        begin
                            done_next       = 1'b1;
                            res_next.status = ST_NO_MEMORY;
                        end
                        else
                        begin
                            ram_raddr  = '0;
                            idx_next   = '0;
                            flags_next = {req.want_present, req.want_writeable,
                                          req.want_user};
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (req.page_frame == '0)
                        begin
                            done_next       = 1'b1;
                            res_next.status = ST_NOT_HELD;
                        end
                        else if (32'(req.page_frame) >= 32'(MAX_FRAMES))
                        begin
                            // Beyond the bitmap: nothing to clear, still done.
                            done_next       = 1'b1;
                            res_next.status = ST_DONE;
                        end
                        else
                        begin
                            ram_raddr  = ADDR_W'(req.page_frame[PF_W-1:BIT_W]);
                            idx_next   = ADDR_W'(req.page_frame[PF_W-1:BIT_W]);
                            bit_next   = req.page_frame[BIT_W-1:0];
                            state_next = S_FREE;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (ram_rdata != '1)
                begin
                    ram_we                 = 1'b1;
                    ram_waddr              = idx_reg;
                    ram_wdata              = ram_rdata | (WORD_BITS'(1) << zero_bit);
                    done_next              = 1'b1;
                    res_next.result_frame  = PF_W'(found_frame);
                    res_next.present_bit   = flags_reg[2];
                    res_next.writeable_bit = flags_reg[1];
                    res_next.user_bit      = flags_reg[0];
                    res_next.status        = ST_DONE;
                    state_next             = S_IDLE;
                end
                else if (LIM_W'(idx_plus) == words)
                begin
                    done_next       = 1'b1;
                    res_next        = '0;
                    res_next.status = ST_NO_MEMORY;
                    state_next      = S_IDLE;
                end
                else
                begin
                    idx_next  = ADDR_W'(idx_plus);
                    ram_raddr = ADDR_W'(idx_plus);
                end
            end

            S_FREE:
            begin
                ram_we          = 1'b1;
                ram_waddr       = idx_reg;
                ram_wdata       = ram_rdata & ~(WORD_BITS'(1) << bit_reg);
                done_next       = 1'b1;
                res_next        = '0;
                res_next.status = ST_DONE;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= COUNT_RESET;
            idx_reg   <= '0;
            bit_reg   <= '0;
            flags_reg <= '0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            bit_reg   <= bit_next;
            flags_reg <= flags_next;
            done_reg  <= done_next;
            res_reg   <= res_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // The bitmap is only written while a request holds the sequencer.
    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SCAN || state_reg == S_FREE))
        else $error("bitmap written outside a request");

    // A result strobe always leaves the block free for the next transfer.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(done && busy))
        else $error("result strobe while busy");

    // A free finishes its read-modify-write from S_FREE and returns to IDLE with the result strobe.
    a_free_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE) |=> (state_reg == S_IDLE && done))
        else $error("free did not complete");

    // Allocation for an entry that already holds a frame is refused at once.
    a_held_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.req_type == REQ_ALLOC && req.page_frame != '0)
        |=> (done && result.status == ST_HELD && !busy))
        else $error("held-frame allocate not refused");

endmodule
